[src/sdspi_pkg.sv]
`default_nettype none

package sdspi_pkg;

    localparam int OP_W     = 2;
    localparam int BLOCK_W  = 23;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 10;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_START_INIT = 2'd0;
    localparam logic [OP_W-1:0] OP_START_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_RX_BYTE    = 2'd2;

    // Completion status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RESPONSE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_REPLY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_INIT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd4;

    localparam logic [BYTE_W-1:0] CMD0_CODE   = 8'h40;
    localparam logic [BYTE_W-1:0] CMD17_CODE  = 8'h51;
    localparam logic [BYTE_W-1:0] CMD_TRAILER = 8'h95;
    localparam logic [BYTE_W-1:0] IDLE_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] START_TOKEN = 8'hFE;
    localparam logic [BYTE_W-1:0] R1_IDLE     = 8'h01;

    localparam int BLOCK_BYTES = 512;
    localparam int FRAME_BYTES = 6;

endpackage

`default_nettype wire

[src/sdspi_if.sv]
`default_nettype none

interface sdspi_req_if;
    import sdspi_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [BLOCK_W-1:0]  block_number;
    logic [BYTE_W-1:0]   rx_byte;

    modport source (output valid, output operation, output block_number, output rx_byte,
                    input ready);
    modport sink   (input valid, input operation, input block_number, input rx_byte,
                    output ready);
endinterface

interface sdspi_res_if;
    import sdspi_pkg::*;

    logic                valid;
    logic                ready;
    logic                tx_valid;
    logic [BYTE_W-1:0]   tx_byte;
    logic                select_active;
    logic                data_valid;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_data;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic                is_initialized;

    modport source (output valid, output tx_valid, output tx_byte, output select_active,
                    output data_valid, output data_byte, output last_data,
                    output done_res, output status, output is_initialized,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input select_active,
                    input data_valid, input data_byte, input last_data,
                    input done_res, input status, input is_initialized,
                    output ready);
endinterface

`default_nettype wire

[src/sd_spi_init_and_block_read_unit.sv]
`default_nettype none

// SPI-mode host sequencer for an SD card: power-up init (CMD0) and single
// block read (CMD17). Every request (start init, start read, or a byte received
// in the last SPI exchange) yields exactly one result, which asks for the next
// exchange (tx_valid, tx_byte), gives the chip-select level, and carries block
// data bytes and the final status. The block takes one request per clock cycle:
// the whole step is computed in one pass and lands in a single result
// register, which is refilled in the same cycle it is taken, so the rate is
// set only by how fast the result side drains. A request waits only while an
// untaken result sits in that register.
module sd_spi_init_and_block_read_unit #(
    parameter int RESPONSE_TRIES = 8,
    parameter int WAKE_BYTES     = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sdspi_req_if.sink   i_req,
    sdspi_res_if.source o_res
);
    import sdspi_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAKE, PH_CMD, PH_RESP, PH_TOKEN, PH_DATA, PH_CRC
    } t_phase;

    typedef struct packed {
        logic                tx_valid;
        logic [BYTE_W-1:0]   tx_byte;
        logic                select_active;
        logic                data_valid;
        logic [BYTE_W-1:0]   data_byte;
        logic                last_data;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic                is_initialized;
    } t_result;

    localparam logic [CNT_W-1:0] WAKE_LIMIT  = CNT_W'(WAKE_BYTES);
    localparam logic [CNT_W-1:0] TRY_LIMIT   = CNT_W'(RESPONSE_TRIES);
    localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] LAST_DATA   = CNT_W'(BLOCK_BYTES - 1);

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [47:0]        r_frame, n_frame;
    logic               r_reading, n_reading;
    logic               r_init, n_init;
    logic               r_out_valid;
    t_result            r_res, n_res;

    logic               accept;
    logic [CNT_W-1:0]   cnt_inc;
    logic [BYTE_W-1:0]  frame_sel;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign cnt_inc     = r_cnt + 1'b1;

    // Command byte k of the frame goes out most significant first.
    always_comb begin
        unique case (cnt_inc[2:0])
            3'd1:    frame_sel = r_frame[39:32];
            3'd2:    frame_sel = r_frame[31:24];
            3'd3:    frame_sel = r_frame[23:16];
            3'd4:    frame_sel = r_frame[15:8];
            3'd5:    frame_sel = r_frame[7:0];
            default: frame_sel = r_frame[47:40];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_frame   = r_frame;
        n_reading = r_reading;
        n_init    = r_init;
        n_res     = '0;

        if (i_req.operation == OP_START_INIT || i_req.operation == OP_START_READ) begin
            if (r_phase != PH_IDLE) begin
                n_res.done_res = 1'b1;
                n_res.status   = ST_BUSY;
            end else if (i_req.operation == OP_START_INIT) begin
                n_init         = 1'b0;
                n_reading      = 1'b0;
                n_phase        = PH_WAKE;
                n_cnt          = '0;
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = IDLE_BYTE;
            end else if (!r_init) begin
                n_res.done_res = 1'b1;
                n_res.status   = ST_NOT_INIT;
            end else begin
                n_reading      = 1'b1;
                n_frame        = {CMD17_CODE, i_req.block_number, 9'd0, CMD_TRAILER};
                n_phase        = PH_CMD;
                n_cnt          = '0;
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = CMD17_CODE;
            end
        end else if (i_req.operation == OP_RX_BYTE) begin
            unique case (r_phase)
                PH_WAKE: begin
                    n_res.tx_valid = 1'b1;
                    if (cnt_inc < WAKE_LIMIT) begin
                        n_cnt         = cnt_inc;
                        n_res.tx_byte = IDLE_BYTE;
                    end else begin
                        n_frame       = {CMD0_CODE, 32'd0, CMD_TRAILER};
                        n_phase       = PH_CMD;
                        n_cnt         = '0;
                        n_res.tx_byte = CMD0_CODE;
                    end
                end
                PH_CMD: begin
                    n_res.tx_valid = 1'b1;
                    if (cnt_inc < FRAME_LIMIT) begin
                        n_cnt         = cnt_inc;
                        n_res.tx_byte = frame_sel;
                    end else begin
                        n_phase       = PH_RESP;
                        n_cnt         = '0;
                        n_res.tx_byte = IDLE_BYTE;
                    end
                end
                PH_RESP: begin
                    if (!i_req.rx_byte[7]) begin
                        if (r_reading) begin
                            n_phase        = PH_TOKEN;
                            n_cnt          = '0;
                            n_res.tx_valid = 1'b1;
                            n_res.tx_byte  = IDLE_BYTE;
                        end else begin
                            n_phase        = PH_IDLE;
                            n_cnt          = '0;
                            n_reading      = 1'b0;
                            n_res.done_res = 1'b1;
                            if (i_req.rx_byte == R1_IDLE) begin
                                n_init       = 1'b1;
                                n_res.status = ST_OK;
                            end else begin
                                n_res.status = ST_BAD_REPLY;
                            end
                        end
                    end else if (cnt_inc < TRY_LIMIT) begin
                        n_cnt          = cnt_inc;
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = IDLE_BYTE;
                    end else begin
                        n_phase        = PH_IDLE;
                        n_cnt          = '0;
                        n_reading      = 1'b0;
                        n_res.done_res = 1'b1;
                        n_res.status   = ST_NO_RESPONSE;
                    end
                end
                PH_TOKEN: begin
                    if (i_req.rx_byte == IDLE_BYTE) begin
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = IDLE_BYTE;
                    end else if (i_req.rx_byte == START_TOKEN) begin
                        n_phase        = PH_DATA;
                        n_cnt          = '0;
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = IDLE_BYTE;
                    end else begin
                        n_phase        = PH_IDLE;
                        n_cnt          = '0;
                        n_reading      = 1'b0;
                        n_res.done_res = 1'b1;
                        n_res.status   = ST_BAD_REPLY;
                    end
                end
                PH_DATA: begin
                    n_res.data_valid = 1'b1;
                    n_res.data_byte  = i_req.rx_byte;
                    n_res.tx_valid   = 1'b1;
                    n_res.tx_byte    = IDLE_BYTE;
                    if (r_cnt >= LAST_DATA) begin
                        n_res.last_data = 1'b1;
                        n_phase         = PH_CRC;
                        n_cnt           = '0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_CRC: begin
                    // Two CRC bytes are clocked in and dropped.
                    if (r_cnt == '0) begin
                        n_cnt          = CNT_W'(1);
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = IDLE_BYTE;
                    end else begin
                        n_phase        = PH_IDLE;
                        n_cnt          = '0;
                        n_reading      = 1'b0;
                        n_res.done_res = 1'b1;
                        n_res.status   = ST_OK;
                    end
                end
                default: begin
                end
            endcase
        end

        n_res.select_active  = (n_phase != PH_IDLE) && (n_phase != PH_WAKE);
        n_res.is_initialized = n_init;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_frame     <= '0;
            r_reading   <= 1'b0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_frame     <= n_frame;
                r_reading   <= n_reading;
                r_init      <= n_init;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.tx_valid       = r_res.tx_valid;
    assign o_res.tx_byte        = r_res.tx_byte;
    assign o_res.select_active  = r_res.select_active;
    assign o_res.data_valid     = r_res.data_valid;
    assign o_res.data_byte      = r_res.data_byte;
    assign o_res.last_data      = r_res.last_data;
    assign o_res.done_res       = r_res.done_res;
    assign o_res.status         = r_res.status;
    assign o_res.is_initialized = r_res.is_initialized;

endmodule

`default_nettype wire

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdspi_pkg::*;

    localparam int RESPONSE_TRIES = 8;
    localparam int WAKE_BYTES     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int REQUEST_COUNT  = 1450;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int LONG_STALL     = 80;

    // The field is two bits wide; the fourth code is no operation at all.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_WAKE, SEQ_CMD, SEQ_RESP, SEQ_TOKEN, SEQ_DATA, SEQ_CRC
    } t_seq_phase;

    typedef struct packed {
        t_seq_phase         phase;
        logic [CNT_W-1:0]   count;
        logic [47:0]        frame;
        logic               reading;
        logic               initialized;
    } t_host_state;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [BLOCK_W-1:0] block_number;
        logic [BYTE_W-1:0]  rx_byte;
        logic               drain;
    } t_host_req;

    typedef struct packed {
        logic                tx_valid;
        logic [BYTE_W-1:0]   tx_byte;
        logic                select_active;
        logic                data_valid;
        logic [BYTE_W-1:0]   data_byte;
        logic                last_data;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic                is_initialized;
    } t_host_res;

    logic i_clk;
    logic i_rst_n = 1'b0;

    sdspi_req_if req_bus ();
    sdspi_res_if res_bus ();

    sd_spi_init_and_block_read_unit #(
        .RESPONSE_TRIES(RESPONSE_TRIES),
        .WAKE_BYTES    (WAKE_BYTES)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_res  (res_bus)
    );

    t_host_req   pending_requests[$];
    t_host_res   expected_results[$];
    t_host_state plan_state;
    t_host_state check_state;
    t_host_req   offered;
    int          planned;
    int          full_reads;
    int          accepted_cnt;
    int          taken_cnt;
    int          mismatches;
    int          req_gap;
    int          res_wait;
    int          long_stall;
    logic        stall_done;
    int          cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // One request of the sequencer: returns the result it yields and advances the state.
    function automatic t_host_res host_step(inout t_host_state st, input t_host_req rq);
        t_host_res           r;
        logic                ends;
        logic [STATUS_W-1:0] code;
        logic [47:0]         shifted;
        r    = '0;
        ends = 1'b0;
        code = ST_OK;
        if (rq.operation == OP_START_INIT || rq.operation == OP_START_READ) begin
            if (st.phase != SEQ_IDLE) begin
                r.done_res = 1'b1;
                r.status   = ST_BUSY;
            end else if (rq.operation == OP_START_INIT) begin
                st.initialized = 1'b0;
                st.reading     = 1'b0;
                st.phase       = SEQ_WAKE;
                st.count       = '0;
                r.tx_valid     = 1'b1;
                r.tx_byte      = IDLE_BYTE;
            end else if (!st.initialized) begin
                r.done_res = 1'b1;
                r.status   = ST_NOT_INIT;
            end else begin
                st.reading = 1'b1;
                st.frame   = {CMD17_CODE, rq.block_number, 9'd0, CMD_TRAILER};
                st.phase   = SEQ_CMD;
                st.count   = '0;
                r.tx_valid = 1'b1;
                r.tx_byte  = st.frame[47:40];
            end
        end else if (rq.operation == OP_RX_BYTE) begin
            case (st.phase)
                SEQ_WAKE: begin
                    st.count   = st.count + 1'b1;
                    r.tx_valid = 1'b1;
                    if (st.count < WAKE_BYTES) begin
                        r.tx_byte = IDLE_BYTE;
                    end else begin
                        st.frame  = {CMD0_CODE, 32'd0, CMD_TRAILER};
                        st.phase  = SEQ_CMD;
                        st.count  = '0;
                        r.tx_byte = st.frame[47:40];
                    end
                end
                SEQ_CMD: begin
                    st.count   = st.count + 1'b1;
                    r.tx_valid = 1'b1;
                    if (st.count < FRAME_BYTES) begin
                        shifted   = st.frame << (8 * st.count);
                        r.tx_byte = shifted[47:40];
                    end else begin
                        st.phase  = SEQ_RESP;
                        st.count  = '0;
                        r.tx_byte = IDLE_BYTE;
                    end
                end
                SEQ_RESP: begin
                    if (!rq.rx_byte[7]) begin
                        if (st.reading) begin
                            st.phase   = SEQ_TOKEN;
                            st.count   = '0;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = IDLE_BYTE;
                        end else if (rq.rx_byte == R1_IDLE) begin
                            st.initialized = 1'b1;
                            ends           = 1'b1;
                        end else begin
                            ends = 1'b1;
                            code = ST_BAD_REPLY;
                        end
                    end else begin
                        st.count = st.count + 1'b1;
                        if (st.count < RESPONSE_TRIES) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = IDLE_BYTE;
                        end else begin
                            ends = 1'b1;
                            code = ST_NO_RESPONSE;
                        end
                    end
                end
                SEQ_TOKEN: begin
                    if (rq.rx_byte == IDLE_BYTE || rq.rx_byte == START_TOKEN) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = IDLE_BYTE;
                        if (rq.rx_byte == START_TOKEN) begin
                            st.phase = SEQ_DATA;
                            st.count = '0;
                        end
                    end else begin
                        ends = 1'b1;
                        code = ST_BAD_REPLY;
                    end
                end
                SEQ_DATA: begin
                    r.data_valid = 1'b1;
                    r.data_byte  = rq.rx_byte;
                    r.tx_valid   = 1'b1;
                    r.tx_byte    = IDLE_BYTE;
                    if (st.count >= BLOCK_BYTES - 1) begin
                        r.last_data = 1'b1;
                        st.phase    = SEQ_CRC;
                        st.count    = '0;
                    end else begin
                        st.count = st.count + 1'b1;
                    end
                end
                SEQ_CRC: begin
                    if (st.count == 0) begin
                        st.count   = CNT_W'(1);
                        r.tx_valid = 1'b1;
                        r.tx_byte  = IDLE_BYTE;
                    end else begin
                        ends = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (ends) begin
            st.phase   = SEQ_IDLE;
            st.count   = '0;
            st.reading = 1'b0;
            r.done_res = 1'b1;
            r.status   = code;
        end
        r.select_active  = (st.phase != SEQ_IDLE && st.phase != SEQ_WAKE);
        r.is_initialized = st.initialized;
        return r;
    endfunction

    // Gaps are drawn per request, except in calm stretches where both sides run flat out.
    function automatic int idle_draw(int idx);
        return ((idx / 128) % 4 == 1) ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_block();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return BLOCK_W'($urandom_range(0, (1 << BLOCK_W) - 1));
    endfunction

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk,
                                 input logic [BYTE_W-1:0] rx, input logic drain);
        t_host_req rq;
        t_host_res outcome;
        rq.operation    = op;
        rq.block_number = blk;
        rq.rx_byte      = rx;
        rq.drain        = drain;
        if (!(op == OP_UNUSED || (op == OP_RX_BYTE && plan_state.phase == SEQ_IDLE)))
            planned++;
        outcome = host_step(plan_state, rq);
        if (outcome.last_data)
            full_reads++;
        pending_requests.push_back(rq);
    endtask

    initial begin
        int                 roll;
        int                 drain_mark;
        int                 miss_left;
        int                 ff_left;
        logic               answer_ok;
        logic               token_ok;
        logic               eager;
        logic               drain;
        logic [BLOCK_W-1:0] blk;
        logic [BYTE_W-1:0]  rx;

        plan_state  = '0;
        check_state = '0;
        miss_left   = 0;
        ff_left     = 0;
        answer_ok   = 1'b1;
        token_ok    = 1'b1;

        // Directed: stray bytes, read before init, busy start, and an init that times out.
        queue_request(OP_RX_BYTE, '0, IDLE_BYTE, 1'b0);
        queue_request(OP_UNUSED, '1, '1, 1'b0);
        queue_request(OP_START_READ, '1, '0, 1'b0);
        queue_request(OP_START_INIT, '0, '0, 1'b0);
        for (int i = 0; i < WAKE_BYTES; i++)
            queue_request(OP_RX_BYTE, '0, (i % 2 == 1) ? 8'h00 : 8'hFF, 1'b0);
        queue_request(OP_START_READ, '1, '0, 1'b0);
        for (int i = 0; i < FRAME_BYTES; i++)
            queue_request(OP_RX_BYTE, '1, BYTE_W'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < RESPONSE_TRIES; i++)
            queue_request(OP_RX_BYTE, '0, 8'h80 | BYTE_W'($urandom_range(0, 127)), 1'b0);

        drain_mark = planned;
        while (planned < REQUEST_COUNT) begin
            roll  = $urandom_range(0, 99);
            blk   = pick_block();
            rx    = BYTE_W'($urandom_range(0, 255));
            drain = 1'b0;
            if (planned >= drain_mark) begin
                drain      = 1'b1;
                drain_mark = drain_mark + 400;
            end
            if (plan_state.phase == SEQ_IDLE) begin
                // Until one block has been read in full, steer toward a clean read.
                eager     = (full_reads == 0);
                ff_left   = $urandom_range(0, 4);
                answer_ok = eager || ($urandom_range(0, 99) < 80);
                token_ok  = eager || ($urandom_range(0, 99) < 80);
                roll      = eager ? 50 : roll;
                case ($urandom_range(0, 9))
                    0:       miss_left = eager ? 0 : RESPONSE_TRIES;
                    1, 2, 3: miss_left = $urandom_range(1, RESPONSE_TRIES - 1);
                    default: miss_left = 0;
                endcase
                if (roll < 10)
                    queue_request(roll < 5 ? OP_RX_BYTE : OP_UNUSED, blk, rx, drain);
                else if (plan_state.initialized ? roll < 60 : roll < 18)
                    queue_request(OP_START_READ, blk, rx, drain);
                else
                    queue_request(OP_START_INIT, blk, rx, drain);
            end else if (roll < 3) begin
                queue_request(roll == 1 ? OP_START_READ : OP_START_INIT, blk, rx, drain);
            end else if (roll < 5) begin
                queue_request(OP_UNUSED, blk, rx, drain);
            end else begin
                case (plan_state.phase)
                    SEQ_RESP: begin
                        if (miss_left != 0) begin
                            rx        = rx | 8'h80;
                            miss_left = miss_left - 1;
                        end else if (plan_state.reading || !answer_ok) begin
                            rx = rx & 8'h7F;
                        end else begin
                            rx = R1_IDLE;
                        end
                    end
                    SEQ_TOKEN: begin
                        if (ff_left != 0) begin
                            rx      = IDLE_BYTE;
                            ff_left = ff_left - 1;
                        end else if (token_ok) begin
                            rx = START_TOKEN;
                        end
                    end
                    default: ;
                endcase
                queue_request(OP_RX_BYTE, blk, rx, drain);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !req_bus.valid && accepted_cnt == taken_cnt);
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
        end
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("sd_spi_init_and_block_read_unit verification clean");
        end else begin
            $display("sd_spi_init_and_block_read_unit verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin : drive_requests
        t_host_req nxt;
        logic      took;
        logic      slot_free;
        if (!i_rst_n) begin
            req_bus.valid        <= 1'b0;
            req_bus.operation    <= OP_RX_BYTE;
            req_bus.block_number <= '0;
            req_bus.rx_byte      <= '0;
            req_gap              <= 0;
            accepted_cnt         <= 0;
        end else begin
            took      = req_bus.valid && req_bus.ready;
            slot_free = !req_bus.valid || took;
            if (took) begin
                expected_results.push_back(host_step(check_state, offered));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (slot_free) begin
                if (req_gap != 0) begin
                    req_gap       <= req_gap - 1;
                    req_bus.valid <= 1'b0;
                end else if (pending_requests.size() != 0 &&
                             (!pending_requests[0].drain ||
                              accepted_cnt + int'(took) == taken_cnt)) begin
                    nxt = pending_requests.pop_front();
                    offered              <= nxt;
                    req_bus.valid        <= 1'b1;
                    req_bus.operation    <= nxt.operation;
                    req_bus.block_number <= nxt.block_number;
                    req_bus.rx_byte      <= nxt.rx_byte;
                    req_gap              <= idle_draw(accepted_cnt);
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the result side, so the result register fills and requests back up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_stall <= 0;
            stall_done <= 1'b0;
        end else if (!stall_done && taken_cnt == 300) begin
            long_stall <= LONG_STALL;
            stall_done <= 1'b1;
        end else if (long_stall != 0) begin
            long_stall <= long_stall - 1;
        end
    end

    always @(posedge i_clk) begin : take_results
        t_host_res want;
        t_host_res got;
        int        w;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            res_wait      <= 0;
            taken_cnt     <= 0;
            mismatches    <= 0;
        end else begin
            w = res_wait;
            if (res_bus.valid && res_bus.ready) begin
                taken_cnt <= taken_cnt + 1;
                got = {res_bus.tx_valid, res_bus.tx_byte, res_bus.select_active,
                       res_bus.data_valid, res_bus.data_byte, res_bus.last_data,
                       res_bus.done_res, res_bus.status, res_bus.is_initialized};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("result %0d arrived with nothing expected", taken_cnt);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("res %0d: tx %b/%h cs %b d %b/%h l %b dn %b st %0d i %b",
                                     taken_cnt, got.tx_valid, got.tx_byte, got.select_active,
                                     got.data_valid, got.data_byte, got.last_data,
                                     got.done_res, got.status, got.is_initialized);
                            $display("  want tx %b/%h cs %b d %b/%h l %b dn %b st %0d i %b",
                                     want.tx_valid, want.tx_byte, want.select_active,
                                     want.data_valid, want.data_byte, want.last_data,
                                     want.done_res, want.status, want.is_initialized);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
                w = idle_draw(taken_cnt);
            end else if (w != 0) begin
                w = w - 1;
            end
            res_wait      <= w;
            res_bus.ready <= (w == 0) && (long_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("sd_spi_init_and_block_read_unit verification failed");
            $finish;
        end
    end

endmodule
